### sv/vbr_pkg.sv
// vbr_pkg: shared constants and types for the visibility baseline remapper
// no dependencies; used by visibility_baseline_remapper_core
`default_nettype none

package vbr_pkg;

    // default array size and channel limit
    localparam int unsigned ANT_COUNT_DEF    = 128;
    localparam int unsigned MAX_CHANNELS_DEF = 1024;

    // remap table geometry
    localparam int unsigned MAP_W     = 8;
    localparam int unsigned MAP_DEPTH = 256;

    // field widths
    localparam int unsigned CHAN_W = 10;
    localparam int unsigned BL_W   = 14;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned OFF_W  = 17;

    // stream widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 96;

    // square root: 8*b+1 fits 17 bits, one result bit per step
    localparam int unsigned RAD_W      = 17;
    localparam int unsigned ROOT_W     = 18;
    localparam int unsigned ROOT_STEPS = 9;

    // item kind carried on tuser
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    // payload of one item in flight
    typedef struct packed {
        logic              load;
        logic [MAP_W-1:0]  slot;
        logic [MAP_W-1:0]  target;
        logic [CHAN_W-1:0] channel;
        logic [BL_W-1:0]   bl;
        logic              pol_first;
        logic              pol_second;
        logic [WORD_W-1:0] re;
        logic [WORD_W-1:0] im;
    } item_t;

endpackage

`default_nettype wire

### sv/vbr_ram.sv
// vbr_ram: generic single-write, single-read RAM with registered read data
// uses no package
`default_nettype none

module vbr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/visibility_baseline_remapper_core.sv
// visibility_baseline_remapper_core: top level of the baseline remapper
// depends on vbr_pkg and vbr_ram
//
//  channel | direction | tdata (low bit up)                               | tuser
//  s_axis  | in        | map_slot, map_target, channel, source_bl,        | cmd
//          |           | src_pol_first, src_pol_second, real, imag        |
//  m_axis  | out       | out_channel, dest_offset, out_real, out_imag     | conjugated
//
// one transfer per cycle in both directions while the pipeline is not stalled; a sample
// result passes the input register (loaded by the transfer), nine square-root steps,
// decode, table read and output register. a table load is written into the memory from
// the decode register, at the edge where samples read, so later samples see it.
// reset clears all valid bits; table contents are kept. the pipeline stalls only
// when the output register holds an untaken result and a new result is due.
`default_nettype none

module visibility_baseline_remapper_core #(
    parameter int unsigned ANT_COUNT    = vbr_pkg::ANT_COUNT_DEF,
    parameter int unsigned MAX_CHANNELS = vbr_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // map_slot[7:0], map_target[15:8], channel[25:16], source_bl[39:26],
    // src_pol_first[40], src_pol_second[41], real_bits[73:42], imag_bits[105:74]
    input  wire logic [vbr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  wire logic [0:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_channel[9:0], dest_offset[26:10], out_real_bits[58:27], out_imag_bits[90:59]
    output logic      [vbr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // conjugated[0]
    output logic      [0:0]                     m_axis_tuser
);

    localparam int unsigned BL_COUNT = ANT_COUNT * (ANT_COUNT + 1) / 2;
    localparam int unsigned LAST     = vbr_pkg::ROOT_STEPS;
    localparam int unsigned MAP_AW   = $clog2(vbr_pkg::MAP_DEPTH);

    logic adv;

    // input unpack and range check
    vbr_pkg::item_t in_item;
    logic           in_range;

    always_comb begin
        in_item.load       = (s_axis_tuser[0] == vbr_pkg::CMD_LOAD);
        in_item.slot       = s_axis_tdata[7:0];
        in_item.target     = s_axis_tdata[15:8];
        in_item.channel    = s_axis_tdata[25:16];
        in_item.bl         = s_axis_tdata[39:26];
        in_item.pol_first  = s_axis_tdata[40];
        in_item.pol_second = s_axis_tdata[41];
        in_item.re         = s_axis_tdata[73:42];
        in_item.im         = s_axis_tdata[105:74];
        in_range = (32'(in_item.bl) < BL_COUNT) && (32'(in_item.channel) < MAX_CHANNELS);
    end

    // input stage and square-root steps
    logic                         valid_reg [0:LAST];
    vbr_pkg::item_t               item_reg  [0:LAST];
    logic [vbr_pkg::RAD_W-1:0]    rem_reg   [0:LAST];
    logic [vbr_pkg::ROOT_W-1:0]   root_reg  [0:LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= s_axis_tvalid && (in_item.load || in_range);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= in_item;
            rem_reg[0]  <= {in_item.bl, 3'b000} + vbr_pkg::RAD_W'(1);
            root_reg[0] <= '0;
        end
    end

    // one root step per stage: bit weight 4^(8-k)
    for (genvar k = 0; k < LAST; k++) begin : g_root
        localparam logic [vbr_pkg::ROOT_W-1:0] BIT =
            vbr_pkg::ROOT_W'(1) << (2 * (LAST - 1 - k));

        logic [vbr_pkg::ROOT_W-1:0] sum;
        logic                       ge;
        logic [vbr_pkg::RAD_W-1:0]  rem_next;
        logic [vbr_pkg::ROOT_W-1:0] root_next;

        always_comb begin
            sum       = root_reg[k] + BIT;
            ge        = {1'b0, rem_reg[k]} >= sum;
            rem_next  = ge ? (rem_reg[k] - sum[vbr_pkg::RAD_W-1:0]) : rem_reg[k];
            root_next = ge ? ((root_reg[k] >> 1) + BIT) : (root_reg[k] >> 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (adv) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                item_reg[k+1] <= item_reg[k];
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
            end
        end
    end

    // antenna pair from root: a1 = (root-1)/2, a2 = b - a1*(a1+1)/2
    // source input indices keep a ninth bit for the order compare
    logic [8:0]  root_m1;
    logic [7:0]  a1_w;
    logic [8:0]  a1_p1;
    logic [16:0] prod_a;
    logic [15:0] tri_w;
    logic [15:0] diff_w;
    logic [8:0]  s1_w;
    logic [8:0]  s2_w;

    always_comb begin
        root_m1 = root_reg[LAST][8:0] - 9'd1;
        a1_w    = root_m1[8:1];
        a1_p1   = {1'b0, a1_w} + 9'd1;
        prod_a  = 17'(a1_w) * 17'(a1_p1);
        tri_w   = prod_a[16:1];
        diff_w  = {2'b00, item_reg[LAST].bl} - tri_w;
        s1_w    = {a1_w, item_reg[LAST].pol_first};
        s2_w    = {diff_w[7:0], item_reg[LAST].pol_second};
    end

    // decode stage
    logic           dec_valid_reg;
    vbr_pkg::item_t dec_item_reg;
    logic [8:0]     dec_s1_reg;
    logic [8:0]     dec_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (adv) begin
            dec_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dec_item_reg <= item_reg[LAST];
            dec_s1_reg   <= s1_w;
            dec_s2_reg   <= s2_w;
        end
    end

    // remap table, one copy per read index; loads write both
    // table address is the low byte of the input index
    logic                     tbl_we;
    logic [vbr_pkg::MAP_W-1:0] d1_w;
    logic [vbr_pkg::MAP_W-1:0] d2_w;

    assign tbl_we = adv && dec_valid_reg && dec_item_reg.load;

    vbr_ram #(
        .WIDTH (vbr_pkg::MAP_W),
        .DEPTH (vbr_pkg::MAP_DEPTH)
    ) u_tbl_first (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (MAP_AW'(dec_item_reg.slot)),
        .wdata (dec_item_reg.target),
        .re    (adv),
        .raddr (MAP_AW'(dec_s1_reg)),
        .rdata (d1_w)
    );

    vbr_ram #(
        .WIDTH (vbr_pkg::MAP_W),
        .DEPTH (vbr_pkg::MAP_DEPTH)
    ) u_tbl_second (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (MAP_AW'(dec_item_reg.slot)),
        .wdata (dec_item_reg.target),
        .re    (adv),
        .raddr (MAP_AW'(dec_s2_reg)),
        .rdata (d2_w)
    );

    // table read stage
    logic           rd_valid_reg;
    vbr_pkg::item_t rd_item_reg;
    logic [8:0]     rd_s1_reg;
    logic [8:0]     rd_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (adv) begin
            rd_valid_reg <= dec_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_item_reg <= dec_item_reg;
            rd_s1_reg   <= dec_s1_reg;
            rd_s2_reg   <= dec_s2_reg;
        end
    end

    // destination baseline, offset and conjugation
    logic        swap;
    logic [6:0]  hi;
    logic [6:0]  lo;
    logic        pol_hi;
    logic        pol_lo;
    logic [7:0]  hi_p1;
    logic [14:0] prod_d;
    logic [13:0] dbl;
    logic [vbr_pkg::OFF_W-1:0] off_next;
    logic        conj_next;

    always_comb begin
        swap      = d2_w[7:1] > d1_w[7:1];
        hi        = swap ? d2_w[7:1] : d1_w[7:1];
        lo        = swap ? d1_w[7:1] : d2_w[7:1];
        pol_hi    = swap ? d2_w[0] : d1_w[0];
        pol_lo    = swap ? d1_w[0] : d2_w[0];
        hi_p1     = {1'b0, hi} + 8'd1;
        prod_d    = 15'(hi) * 15'(hi_p1);
        dbl       = prod_d[14:1] + {7'b0000000, lo};
        off_next  = {dbl, pol_hi, pol_lo, 1'b0};
        conj_next = !(((rd_s1_reg < rd_s2_reg) && (d1_w < d2_w)) ||
                      ((rd_s1_reg > rd_s2_reg) && (d1_w > d2_w)));
    end

    // output register
    logic                        rd_result;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [vbr_pkg::CHAN_W-1:0]  out_channel_reg;
    logic [vbr_pkg::OFF_W-1:0]   out_offset_reg;
    logic [vbr_pkg::WORD_W-1:0]  out_real_reg;
    logic [vbr_pkg::WORD_W-1:0]  out_imag_reg;
    logic                        out_conj_reg;

    assign rd_result = rd_valid_reg && !rd_item_reg.load;

    // stall only when a new result would overwrite an untaken one
    assign adv = !(out_valid_reg && !m_axis_tready && rd_result);
    assign s_axis_tready = adv;

    always_comb begin
        if (adv && rd_result) begin
            out_valid_next = 1'b1;
        end else begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && rd_result) begin
            out_channel_reg <= rd_item_reg.channel;
            out_offset_reg  <= off_next;
            out_real_reg    <= rd_item_reg.re;
            out_imag_reg    <= {rd_item_reg.im[31] ^ conj_next, rd_item_reg.im[30:0]};
            out_conj_reg    <= conj_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_imag_reg, out_real_reg, out_offset_reg,
                            out_channel_reg};
    assign m_axis_tuser  = out_conj_reg;

    // input is refused only behind a blocked result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // root decode gives a valid lower-triangular pair
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[LAST] && !item_reg[LAST].load) |->
            ((tri_w <= {2'b00, item_reg[LAST].bl}) && (diff_w <= {8'h00, a1_w})))
        else $error("baseline decode out of triangle");

    // a sample leaving the read stage shows up on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && rd_result) |=> m_axis_tvalid)
        else $error("sample result lost");

endmodule

`default_nettype wire
